### hw/rtl/ptc_pkg.sv
// shared types, constants and arithmetic helpers of the compensation pipeline
`timescale 1ns / 1ps

package ptc_pkg;

    // calibration register file
    localparam int unsigned NumCal   = 6;
    localparam int unsigned PaddrW   = 5;
    // bits of quotient produced by the divider, one per stage
    localparam int unsigned DivBits  = 64;

    // input word
    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } t_in_word;

    // result word
    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic        [31:0] pressure_q24_8;
        logic               divide_by_zero;
    } t_out_word;

    // calibration coefficients unpacked from the registers
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_coef;

    // word traveling through the divider stages
    typedef struct packed {
        logic [63:0] work;
        logic [30:0] rem;
        logic [30:0] md;
        logic        neg;
        logic        dz;
        logic [31:0] temp;
        logic [31:0] tfine;
    } t_div_word;

    // 64-bit wrapping product of a 64-bit word and a signed 17-bit coefficient
    function automatic logic [63:0] mul_s64(input logic [63:0] a,
                                            input logic signed [16:0] b);
        logic signed [49:0] lo;
        logic signed [48:0] hi;
        lo = $signed({1'b0, a[31:0]}) * b;
        hi = $signed(a[63:32]) * b;
        return {{14{lo[49]}}, lo} + {hi[31:0], 32'd0};
    endfunction

    // 64-bit wrapping square
    function automatic logic [63:0] sq64(input logic [63:0] a);
        logic [63:0] ll;
        logic [31:0] lh;
        ll = a[31:0] * a[31:0];
        lh = a[31:0] * a[63:32];
        return ll + {lh[30:0], 33'd0};
    endfunction

endpackage

### hw/rtl/pressure_temperature_compensation_unit.sv
// top level of the barometric temperature and pressure compensation pipeline
`timescale 1ns / 1ps

// Input channel: i_in_valid / o_in_ready carry one word of raw temperature and
// raw pressure. Output channel: o_out_valid / i_out_ready carry one word of
// centi-degree temperature, fine temperature, Q24.8 pressure and the
// zero-divisor flag. A word moves when valid and ready are both high.
// Calibration lives in six 32-bit registers on the APB-style port at byte
// addresses 0x00..0x14; write them only while no word is in flight.
// Throughput: one word per cycle while the receiver keeps up. A word passes
// through ten arithmetic stages ahead of the divider, 64 divider stages
// (one quotient bit each), four correction stages and the output
// register. The whole pipeline advances together; when the receiver stalls,
// one more word lands in a skid entry, then o_in_ready drops and every stage
// holds its contents until the output word is taken.
// Reset clears all valid bits, the output and skid flags, and the
// calibration registers to zero.

module pressure_temperature_compensation_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ptc_pkg::t_in_word            i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ptc_pkg::t_out_word           o_out_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptc_pkg::PaddrW-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    typedef enum logic [2:0] {
        CAL_T1_T2 = 3'd0,
        CAL_T3_P1 = 3'd1,
        CAL_P2_P3 = 3'd2,
        CAL_P4_P5 = 3'd3,
        CAL_P6_P7 = 3'd4,
        CAL_P8_P9 = 3'd5
    } t_cal_idx;

    logic [31:0]        r_cal [ptc_pkg::NumCal];
    logic [2:0]         cal_idx;
    ptc_pkg::t_coef     coef;
    logic               en;
    logic               front_vld;
    ptc_pkg::t_div_word front_word;
    logic               div_vld;
    ptc_pkg::t_div_word div_word;
    logic               back_vld;
    ptc_pkg::t_out_word back_word;

    assign cal_idx = paddr[4:2];
    assign pready  = 1'b1;

    // calibration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ptc_pkg::NumCal; k++) begin
                r_cal[k] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            unique case (cal_idx)
                CAL_T1_T2: r_cal[CAL_T1_T2] <= pwdata;
                CAL_T3_P1: r_cal[CAL_T3_P1] <= pwdata;
                CAL_P2_P3: r_cal[CAL_P2_P3] <= pwdata;
                CAL_P4_P5: r_cal[CAL_P4_P5] <= pwdata;
                CAL_P6_P7: r_cal[CAL_P6_P7] <= pwdata;
                CAL_P8_P9: r_cal[CAL_P8_P9] <= pwdata;
                default: ;
            endcase
        end
    end

    // register read mux
    always_comb begin
        unique case (cal_idx)
            CAL_T1_T2: prdata = r_cal[CAL_T1_T2];
            CAL_T3_P1: prdata = r_cal[CAL_T3_P1];
            CAL_P2_P3: prdata = r_cal[CAL_P2_P3];
            CAL_P4_P5: prdata = r_cal[CAL_P4_P5];
            CAL_P6_P7: prdata = r_cal[CAL_P6_P7];
            CAL_P8_P9: prdata = r_cal[CAL_P8_P9];
            default:   prdata = '0;
        endcase
    end

    // coefficient unpacking
    always_comb begin
        coef.t1 = r_cal[CAL_T1_T2][15:0];
        coef.t2 = r_cal[CAL_T1_T2][31:16];
        coef.t3 = r_cal[CAL_T3_P1][15:0];
        coef.p1 = r_cal[CAL_T3_P1][31:16];
        coef.p2 = r_cal[CAL_P2_P3][15:0];
        coef.p3 = r_cal[CAL_P2_P3][31:16];
        coef.p4 = r_cal[CAL_P4_P5][15:0];
        coef.p5 = r_cal[CAL_P4_P5][31:16];
        coef.p6 = r_cal[CAL_P6_P7][15:0];
        coef.p7 = r_cal[CAL_P6_P7][31:16];
        coef.p8 = r_cal[CAL_P8_P9][15:0];
        coef.p9 = r_cal[CAL_P8_P9][31:16];
    end

    assign o_in_ready = en;

    ptc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .i_coef  (coef),
        .o_valid (front_vld),
        .o_word  (front_word)
    );

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_vld),
        .i_word  (front_word),
        .o_valid (div_vld),
        .o_word  (div_word)
    );

    ptc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_vld),
        .i_word  (div_word),
        .i_coef  (coef),
        .o_valid (back_vld),
        .o_word  (back_word)
    );

    ptc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (back_vld && en),
        .i_word  (back_word),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .o_en    (en)
    );

endmodule

### hw/rtl/ptc_front.sv
// temperature path and pressure terms up to the divider operands
`timescale 1ns / 1ps

module ptc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  ptc_pkg::t_in_word  i_word,
    input  ptc_pkg::t_coef     i_coef,
    output logic               o_valid,
    output ptc_pkg::t_div_word o_word
);

    logic [9:0]          r_vld;
    logic [19:0]         r_praw [1:7];
    logic [31:0]         r_temp [4:9];
    logic [31:0]         r_tf   [4:9];

    logic signed [17:0]  r_a1;
    logic signed [16:0]  r_b1;
    logic [31:0]         r_tv1_2;
    logic signed [19:0]  r_bbs2;
    logic [31:0]         r_tf3;
    logic signed [32:0]  r_v1_4;
    logic [63:0]         r_s5;
    logic signed [48:0]  r_q5_5;
    logic signed [48:0]  r_q2_5;
    logic [63:0]         r_x6_6;
    logic [63:0]         r_x3_6;
    logic signed [48:0]  r_q5_6;
    logic signed [48:0]  r_q2_6;
    logic [63:0]         r_v2_7;
    logic [63:0]         r_t7_7;
    logic [30:0]         r_d8;
    logic [63:0]         r_num0_8;
    logic [63:0]         r_num9;
    logic [30:0]         r_d9;
    logic                r_dz9;
    ptc_pkg::t_div_word  r_out;

    logic signed [17:0]  a1;
    logic signed [16:0]  b1;
    logic signed [33:0]  pa2;
    logic signed [33:0]  pb2;
    logic [31:0]         tv1_2;
    logic signed [35:0]  pc3;
    logic [31:0]         tv2_3;
    logic [31:0]         tf3;
    logic [31:0]         t5_4;
    logic [31:0]         temp4;
    logic signed [32:0]  v1_4;
    logic [63:0]         s5;
    logic signed [48:0]  q5_5;
    logic signed [48:0]  q2_5;
    logic [63:0]         x6_6;
    logic [63:0]         x3_6;
    logic [63:0]         v2_7;
    logic [63:0]         x3s_7;
    logic [63:0]         t7_7;
    logic [63:0]         y8;
    logic [20:0]         pp8;
    logic [63:0]         num0_8;
    logic [63:0]         num9;
    ptc_pkg::t_div_word  n_out;

    // stage arithmetic
    always_comb begin
        // differences against t1
        a1 = $signed({1'b0, i_word.raw_temperature[19:3]}) - $signed({1'b0, i_coef.t1, 1'b0});
        b1 = $signed({1'b0, i_word.raw_temperature[19:4]}) - $signed({1'b0, i_coef.t1});
        // first temperature term and square of b
        pa2   = r_a1 * $signed(i_coef.t2);
        tv1_2 = $signed(pa2[31:0]) >>> 11;
        pb2   = r_b1 * r_b1;
        // second term and fine temperature
        pc3   = r_bbs2 * $signed(i_coef.t3);
        tv2_3 = $signed(pc3[31:0]) >>> 14;
        tf3   = r_tv1_2 + tv2_3;
        // centi degrees and pressure offset variable
        t5_4  = {r_tf3[29:0], 2'b00} + r_tf3 + 32'd128;
        temp4 = $signed(t5_4) >>> 8;
        v1_4  = $signed({r_tf3[31], r_tf3}) - 33'sd128000;
        // square and linear products of v1
        s5    = ptc_pkg::sq64({{31{r_v1_4[32]}}, r_v1_4});
        q5_5  = r_v1_4 * $signed(i_coef.p5);
        q2_5  = r_v1_4 * $signed(i_coef.p2);
        // quadratic coefficient products
        x6_6  = ptc_pkg::mul_s64(r_s5, $signed({i_coef.p6[15], i_coef.p6}));
        x3_6  = ptc_pkg::mul_s64(r_s5, $signed({i_coef.p3[15], i_coef.p3}));
        // sums of the two polynomials
        v2_7  = r_x6_6 + ({{15{r_q5_6[48]}}, r_q5_6} << 17)
                + ({{48{i_coef.p4[15]}}, i_coef.p4} << 35);
        x3s_7 = $signed(r_x3_6) >>> 8;
        t7_7  = x3s_7 + ({{15{r_q2_6[48]}}, r_q2_6} << 12) + 64'h0000_8000_0000_0000;
        // divisor and unscaled dividend
        y8     = ptc_pkg::mul_s64(r_t7_7, $signed({1'b0, i_coef.p1}));
        pp8    = 21'h10_0000 - {1'b0, r_praw[7]};
        num0_8 = {12'd0, pp8, 31'd0} - r_v2_7;
        // scaled dividend
        num9   = ptc_pkg::mul_s64(r_num0_8, 17'sd3125);
        // magnitudes and quotient sign for the divider
        n_out.work  = r_num9[63] ? (64'd0 - r_num9) : r_num9;
        n_out.rem   = '0;
        n_out.md    = r_d9[30] ? (31'd0 - r_d9) : r_d9;
        n_out.neg   = r_num9[63] ^ r_d9[30];
        n_out.dz    = r_dz9;
        n_out.temp  = r_temp[9];
        n_out.tfine = r_tf[9];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1      <= a1;
            r_b1      <= b1;
            r_tv1_2   <= tv1_2;
            r_bbs2    <= pb2[31:12];
            r_tf3     <= tf3;
            r_temp[4] <= temp4;
            r_tf[4]   <= r_tf3;
            r_v1_4    <= v1_4;
            r_s5      <= s5;
            r_q5_5    <= q5_5;
            r_q2_5    <= q2_5;
            r_x6_6    <= x6_6;
            r_x3_6    <= x3_6;
            r_q5_6    <= r_q5_5;
            r_q2_6    <= r_q2_5;
            r_v2_7    <= v2_7;
            r_t7_7    <= t7_7;
            r_d8      <= y8[63:33];
            r_num0_8  <= num0_8;
            r_num9    <= num9;
            r_d9      <= r_d8;
            r_dz9     <= (r_d8 == '0);
            r_out     <= n_out;
            r_praw[1] <= i_word.raw_pressure;
            for (int k = 2; k <= 7; k++) begin
                r_praw[k] <= r_praw[k-1];
            end
            for (int k = 5; k <= 9; k++) begin
                r_temp[k] <= r_temp[k-1];
                r_tf[k]   <= r_tf[k-1];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[8:0], i_valid};
        end
    end

    assign o_valid = r_vld[9];
    assign o_word  = r_out;

endmodule

### hw/rtl/ptc_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module ptc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  ptc_pkg::t_div_word i_word,
    output logic               o_valid,
    output ptc_pkg::t_div_word o_word
);

    ptc_pkg::t_div_word s_word [0:ptc_pkg::DivBits];
    logic               s_vld  [0:ptc_pkg::DivBits];

    assign s_word[0] = i_word;
    assign s_vld[0]  = i_valid;

    for (genvar k = 0; k < ptc_pkg::DivBits; k++) begin : g_stage
        ptc_pkg::t_div_word n_word;
        ptc_pkg::t_div_word r_word;
        logic               r_vld;
        logic [31:0]        trial;
        logic [31:0]        diff;

        // shift in the next dividend bit and try to subtract
        always_comb begin
            trial  = {s_word[k].rem, s_word[k].work[63]};
            diff   = trial - {1'b0, s_word[k].md};
            n_word = s_word[k];
            if (trial >= {1'b0, s_word[k].md}) begin
                n_word.rem  = diff[30:0];
                n_word.work = {s_word[k].work[62:0], 1'b1};
            end else begin
                n_word.rem  = trial[30:0];
                n_word.work = {s_word[k].work[62:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_word <= n_word;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
        end

        assign s_word[k+1] = r_word;
        assign s_vld[k+1]  = r_vld;
    end

    assign o_valid = s_vld[ptc_pkg::DivBits];
    assign o_word  = s_word[ptc_pkg::DivBits];

endmodule

### hw/rtl/ptc_back.sv
// quotient sign, second-order pressure correction and result packing
`timescale 1ns / 1ps

module ptc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  ptc_pkg::t_div_word i_word,
    input  ptc_pkg::t_coef     i_coef,
    output logic               o_valid,
    output ptc_pkg::t_out_word o_word
);

    logic [3:0]          r_vld;
    logic [31:0]         r_temp [1:3];
    logic [31:0]         r_tf   [1:3];
    logic                r_dz   [1:3];
    logic [63:0]         r_q1;
    logic [63:0]         r_q2;
    logic [63:0]         r_sqh2;
    logic [63:0]         r_w2_2;
    logic [63:0]         r_q3;
    logic [63:0]         r_w1_3;
    logic [63:0]         r_w2_3;
    ptc_pkg::t_out_word  r_out;

    logic [63:0]         q1;
    logic [63:0]         ph2;
    logic [63:0]         sqh2;
    logic [63:0]         m8_2;
    logic [63:0]         w2_2;
    logic [63:0]         m9_3;
    logic [63:0]         w1_3;
    logic [63:0]         sum4;
    logic [63:0]         sh4;
    logic [63:0]         x4;
    ptc_pkg::t_out_word  n_out;

    // stage arithmetic
    always_comb begin
        // signed quotient
        q1   = i_word.neg ? (64'd0 - i_word.work) : i_word.work;
        // square of the scaled pressure and linear correction
        ph2  = $signed(r_q1) >>> 13;
        sqh2 = ptc_pkg::sq64(ph2);
        m8_2 = ptc_pkg::mul_s64(r_q1, $signed({i_coef.p8[15], i_coef.p8}));
        w2_2 = $signed(m8_2) >>> 19;
        // quadratic correction
        m9_3 = ptc_pkg::mul_s64(r_sqh2, $signed({i_coef.p9[15], i_coef.p9}));
        w1_3 = $signed(m9_3) >>> 25;
        // final sum and offset
        sum4 = r_q3 + r_w1_3 + r_w2_3;
        sh4  = $signed(sum4) >>> 8;
        x4   = sh4 + ({{48{i_coef.p7[15]}}, i_coef.p7} << 4);
        n_out.temperature_centi = $signed(r_temp[3]);
        n_out.fine_temperature  = $signed(r_tf[3]);
        n_out.pressure_q24_8    = r_dz[3] ? 32'd0 : x4[31:0];
        n_out.divide_by_zero    = r_dz[3];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1      <= q1;
            r_temp[1] <= i_word.temp;
            r_tf[1]   <= i_word.tfine;
            r_dz[1]   <= i_word.dz;
            r_q2      <= r_q1;
            r_sqh2    <= sqh2;
            r_w2_2    <= w2_2;
            r_q3      <= r_q2;
            r_w1_3    <= w1_3;
            r_w2_3    <= r_w2_2;
            r_out     <= n_out;
            for (int k = 2; k <= 3; k++) begin
                r_temp[k] <= r_temp[k-1];
                r_tf[k]   <= r_tf[k-1];
                r_dz[k]   <= r_dz[k-1];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    assign o_valid = r_vld[3];
    assign o_word  = r_out;

endmodule

### hw/rtl/ptc_outbuf.sv
// output register with one skid entry; freezes the pipeline when the skid is full
`timescale 1ns / 1ps

module ptc_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ptc_pkg::t_out_word i_word,
    input  logic               i_ready,
    output logic               o_valid,
    output ptc_pkg::t_out_word o_word,
    output logic               o_en
);

    logic               r_out_vld;
    logic               r_skid_vld;
    ptc_pkg::t_out_word r_out;
    ptc_pkg::t_out_word r_skid;
    logic               take;

    assign take = r_out_vld && i_ready;

    // pipeline moves while the skid entry is free
    assign o_en = !r_skid_vld;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_valid) begin
            if (r_out_vld && !take) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    // word storage
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (i_valid) begin
            if (r_out_vld && !take) begin
                r_skid <= i_word;
            end else begin
                r_out <= i_word;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out;

endmodule

### hw/rtl/ptc_checker.sv
// port-level checks of the compensation unit and their bind
`timescale 1ns / 1ps

module ptc_props (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input ptc_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ptc_pkg::t_out_word o_out_word
);

    logic [31:0] t5;
    logic [31:0] tc;

    // centi degrees follow from the fine temperature
    assign t5 = o_out_word.fine_temperature * 32'sd5 + 32'sd128;
    assign tc = $signed(t5) >>> 8;

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // input is refused only after an output stall
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> $past(o_out_valid) && !$past(i_out_ready))
        else $error("input refused without an output stall");

    // zero divisor forces zero pressure
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.divide_by_zero |-> o_out_word.pressure_q24_8 == 32'd0)
        else $error("pressure not zero on divide by zero");

    // temperature fields agree
    a_temp_fine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.temperature_centi == $signed(tc))
        else $error("temperature does not match fine temperature");

endmodule

bind pressure_temperature_compensation_unit ptc_props u_ptc_props (.*);

### test/ptc_checker.sv
// checker for the compensation unit: predicts each result word and compares it
`timescale 1ns / 1ps

module ptc_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  ptc_pkg::t_in_word    i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  ptc_pkg::t_out_word   i_out_word,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic                 i_pready,
    input  logic [ptc_pkg::PaddrW-1:0] i_paddr,
    input  logic [31:0]          i_pwdata,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [31:0]        cal_shadow [ptc_pkg::NumCal];
    ptc_pkg::t_out_word expected_words [$];

    // arithmetic right shifts on plain vectors
    function automatic logic [31:0] sra32(input logic [31:0] v, input int s);
        logic signed [31:0] sv;
        sv = v;
        return sv >>> s;
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] v, input int s);
        logic signed [63:0] sv;
        sv = v;
        return sv >>> s;
    endfunction

    function automatic logic [63:0] sext16(input logic [15:0] h);
        return {{48{h[15]}}, h};
    endfunction

    // compensation of one raw temperature / pressure pair
    function automatic ptc_pkg::t_out_word compensate(input ptc_pkg::t_in_word w);
        logic [31:0] t1, t2, t3, a, b, tv1, tv2, tf;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, p, n, mn, md, q, ph, w1, w2;
        ptc_pkg::t_out_word r;
        t1 = {16'd0, cal_shadow[0][15:0]};
        t2 = {{16{cal_shadow[0][31]}}, cal_shadow[0][31:16]};
        t3 = {{16{cal_shadow[1][15]}}, cal_shadow[1][15:0]};
        p1 = {48'd0, cal_shadow[1][31:16]};
        p2 = sext16(cal_shadow[2][15:0]);
        p3 = sext16(cal_shadow[2][31:16]);
        p4 = sext16(cal_shadow[3][15:0]);
        p5 = sext16(cal_shadow[3][31:16]);
        p6 = sext16(cal_shadow[4][15:0]);
        p7 = sext16(cal_shadow[4][31:16]);
        p8 = sext16(cal_shadow[5][15:0]);
        p9 = sext16(cal_shadow[5][31:16]);

        // temperature path, 32-bit wrapping
        a   = {15'd0, w.raw_temperature[19:3]} - (t1 << 1);
        tv1 = sra32(a * t2, 11);
        b   = {16'd0, w.raw_temperature[19:4]} - t1;
        tv2 = sra32(sra32(b * b, 12) * t3, 14);
        tf  = tv1 + tv2;
        r.temperature_centi = sra32(tf * 32'd5 + 32'd128, 8);
        r.fine_temperature  = tf;

        // pressure path, 64-bit wrapping
        v1 = {{32{tf[31]}}, tf} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = sra64(((64'd1 << 47) + v1) * p1, 33);

        r.pressure_q24_8 = '0;
        r.divide_by_zero = 1'b0;
        if (v1 == 64'd0) begin
            r.divide_by_zero = 1'b1;
        end else begin
            p  = 64'd1048576 - {44'd0, w.raw_pressure};
            n  = ((p << 31) - v2) * 64'd3125;
            // signed division toward zero, most negative over -1 wraps
            mn = n[63] ? (64'd0 - n) : n;
            md = v1[63] ? (64'd0 - v1) : v1;
            q  = mn / md;
            p  = (n[63] != v1[63]) ? (64'd0 - q) : q;
            ph = sra64(p, 13);
            w1 = sra64(p9 * ph * ph, 25);
            w2 = sra64(p8 * p, 19);
            p  = sra64(p + w1 + w2, 8) + (p7 << 4);
            r.pressure_q24_8 = p[31:0];
        end
        return r;
    endfunction

    // shadow registers, prediction on input words, comparison on output words
    always @(posedge i_clk) begin
        ptc_pkg::t_out_word e;
        if (!i_rst_n) begin
            for (int i = 0; i < ptc_pkg::NumCal; i++) cal_shadow[i] <= '0;
            expected_words.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[4:2] < ptc_pkg::NumCal)
                cal_shadow[i_paddr[4:2]] <= i_pwdata;
            if (i_in_valid && i_in_ready)
                expected_words.push_back(compensate(i_in_word));
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: output word with nothing expected, actual %h",
                             $time, i_out_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_words.pop_front();
                    if (e.temperature_centi !== i_out_word.temperature_centi) begin
                        $display("%0t: temperature_centi expected %0d actual %0d", $time,
                                 e.temperature_centi, i_out_word.temperature_centi);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (e.fine_temperature !== i_out_word.fine_temperature) begin
                        $display("%0t: fine_temperature expected %0d actual %0d", $time,
                                 e.fine_temperature, i_out_word.fine_temperature);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (e.pressure_q24_8 !== i_out_word.pressure_q24_8) begin
                        $display("%0t: pressure_q24_8 expected %h actual %h", $time,
                                 e.pressure_q24_8, i_out_word.pressure_q24_8);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (e.divide_by_zero !== i_out_word.divide_by_zero) begin
                        $display("%0t: divide_by_zero expected %b actual %b", $time,
                                 e.divide_by_zero, i_out_word.divide_by_zero);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_words.size();
        end
    end

endmodule

### test/tb_pressure_temperature_compensation_unit.sv
// stimulus and verdict for the compensation unit testbench
`timescale 1ns / 1ps

module tb_pressure_temperature_compensation_unit;

    localparam int IdleLimit = 5000;
    localparam int HoldCycles = 400;
    localparam int RandomPerPhase = 220;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ptc_pkg::t_in_word in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ptc_pkg::t_out_word out_word;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ptc_pkg::PaddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int fail_count, pending;

    // shared between stimulus and receiver
    logic no_idle = 1'b0;
    int hold_token = 0;

    always #6 i_clk = ~i_clk;

    pressure_temperature_compensation_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ptc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_word(out_word),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random ready, with a long hold-off on request
    always @(posedge i_clk) begin
        static int hold_left = 0;
        static int hold_seen = 0;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HoldCycles;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 13);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        static int quiet = 0;
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
        else quiet++;
        if (quiet >= IdleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic reg_write(input int idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ptc_pkg::PaddrW'(idx * 4); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // drains the pipeline, then loads all six calibration words
    task automatic load_cal(input logic [31:0] c0, c1, c2, c3, c4, c5);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (90) @(posedge i_clk);
        reg_write(0, c0); reg_write(1, c1); reg_write(2, c2);
        reg_write(3, c3); reg_write(4, c4); reg_write(5, c5);
    endtask

    // offers one word and holds it until taken
    task automatic send_word(input logic [19:0] rt, input logic [19:0] rp);
        while (!no_idle && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word.raw_temperature <= rt;
        in_word.raw_pressure <= rp;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic random_words(input int count);
        logic [19:0] rt, rp;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1)) begin
                rt = 20'(519888 + $urandom_range(80000) - 40000);
                rp = 20'(415148 + $urandom_range(200000) - 100000);
            end else begin
                rt = 20'($urandom); rp = 20'($urandom);
            end
            send_word(rt, rp);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset calibration: zero divisor throughout
        send_word(20'd0, 20'd0);
        send_word(20'hFFFFF, 20'hFFFFF);
        send_word(20'd519888, 20'd415148);

        // typical datasheet calibration
        load_cal({16'd26435, 16'd27504}, {16'd36477, -16'sd1000},
                 {16'd3024, -16'sd10685}, {16'd140, 16'd2855},
                 {16'd15500, -16'sd7}, {16'd6000, -16'sd14600});
        send_word(20'd519888, 20'd415148);
        send_word(20'd0, 20'd0);
        send_word(20'hFFFFF, 20'hFFFFF);
        send_word(20'd0, 20'hFFFFF);
        send_word(20'hFFFFF, 20'd0);
        send_word(20'h80000, 20'h80000);
        send_word(20'h7FFFF, 20'h7FFFF);
        random_words(RandomPerPhase);

        // all ones, with a long receiver hold-off while the sender keeps going
        load_cal('1, '1, '1, '1, '1, '1);
        send_word(20'd0, 20'd0);
        send_word(20'hFFFFF, 20'hFFFFF);
        hold_token++;
        random_words(RandomPerPhase);

        // extreme signed halves, no idling on either side
        load_cal(32'h8000_FFFF, 32'hFFFF_8000, 32'h8000_8000, 32'h8000_8000,
                 32'h8000_8000, 32'h8000_8000);
        no_idle <= 1'b1;
        send_word(20'd0, 20'hFFFFF);
        send_word(20'hFFFFF, 20'd0);
        random_words(RandomPerPhase);
        no_idle <= 1'b0;

        // pressure coefficient 1 of zero forces the zero divisor
        load_cal({16'd26435, 16'd27504}, {16'd0, -16'sd1000}, 32'h7FFF_7FFF,
                 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
        send_word(20'd519888, 20'd415148);
        random_words(60);

        // random calibrations
        for (int ph = 0; ph < 3; ph++) begin
            load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            random_words(RandomPerPhase);
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### pressure_temperature_compensation_unit.f
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_front.sv
hw/rtl/ptc_div.sv
hw/rtl/ptc_back.sv
hw/rtl/ptc_outbuf.sv
hw/rtl/pressure_temperature_compensation_unit.sv
hw/rtl/ptc_checker.sv
test/ptc_checker.sv
test/tb_pressure_temperature_compensation_unit.sv
